>>> rtl/core/gcbv_pkg.sv
// Shared constants, CORDIC step table and sizing for the beam visibility block.
// No dependencies.
package gcbv_pkg;

  localparam int unsigned BeamsDef       = 256;
  localparam int unsigned CordicStepsDef = 16;
  localparam int unsigned GridWidthLog2  = 8;   // grid width 256 cells

  localparam int unsigned PosW   = 18;  // dx, dy
  localparam int unsigned VecW   = 28;  // CORDIC x, y
  localparam int unsigned AccW   = 26;  // angle accumulator, 1/65536 deg
  localparam int unsigned AngW   = 20;  // bearing and angle, 1/256 deg
  localparam int unsigned NumW   = 18;  // divider dividend and quotient
  localparam int unsigned StepW  = 5;

  localparam logic signed [AccW-1:0] Deg90     = AccW'(90 * 65536);
  localparam logic signed [AngW-1:0] Offset120 = AngW'(120 * 256);

  localparam logic [1:0] CfgCellSize    = 2'd0;
  localparam logic [1:0] CfgBeamSpacing = 2'd1;
  localparam logic [1:0] CfgFov         = 2'd2;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  function automatic logic [22:0] step_angle(input logic [StepW-1:0] i);
    logic [22:0] a;
    case (i)
      5'd0:  a = 23'd2949120;
      5'd1:  a = 23'd1740967;
      5'd2:  a = 23'd919879;
      5'd3:  a = 23'd466945;
      5'd4:  a = 23'd234379;
      5'd5:  a = 23'd117304;
      5'd6:  a = 23'd58666;
      5'd7:  a = 23'd29335;
      5'd8:  a = 23'd14668;
      5'd9:  a = 23'd7334;
      5'd10: a = 23'd3667;
      5'd11: a = 23'd1833;
      5'd12: a = 23'd917;
      5'd13: a = 23'd458;
      5'd14: a = 23'd229;
      5'd15: a = 23'd115;
      5'd16: a = 23'd57;
      5'd17: a = 23'd29;
      5'd18: a = 23'd14;
      5'd19: a = 23'd7;
      5'd20: a = 23'd4;
      5'd21: a = 23'd2;
      5'd22: a = 23'd1;
      default: a = 23'd0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/core/gcbv_cordic.sv
// Iterative vectoring CORDIC: one micro-rotation per cycle, bearing in 1/256 deg.
// Depends on gcbv_pkg.
module gcbv_cordic #(
  parameter int unsigned Steps = gcbv_pkg::CordicStepsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [gcbv_pkg::PosW-1:0]     dx_i,
  input  logic signed [gcbv_pkg::PosW-1:0]     dy_i,
  output logic                                 done_o,
  output logic signed [gcbv_pkg::AngW-1:0]     bearing_o
);
  import gcbv_pkg::*;

  logic signed [VecW-1:0] x_q, y_q, x_d, y_d, xs, ys, x0, y0;
  logic signed [AccW-1:0] acc_q, acc_d, acc_r;
  logic [StepW-1:0]       cnt_q;
  logic                   busy_q, done_q, zero_q;

  always_comb begin
    x0    = VecW'(dx_i) <<< 8;
    y0    = VecW'(dy_i) <<< 8;
    x_d   = x0;
    y_d   = y0;
    acc_d = '0;
    if (x0 < 0) begin
      if (y0 >= 0) begin
        x_d = y0;  y_d = -x0; acc_d = Deg90;
      end else begin
        x_d = -y0; y_d = x0;  acc_d = -Deg90;
      end
    end
  end

  assign xs = x_q >>> cnt_q;
  assign ys = y_q >>> cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == StepW'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      acc_q  <= acc_d;
      zero_q <= (dx_i == '0) && (dy_i == '0);
    end else if (busy_q) begin
      if (y_q >= 0) begin
        x_q   <= x_q + ys;
        y_q   <= y_q - xs;
        acc_q <= acc_q + AccW'(step_angle(cnt_q));
      end else begin
        x_q   <= x_q - ys;
        y_q   <= y_q + xs;
        acc_q <= acc_q - AccW'(step_angle(cnt_q));
      end
    end
  end

  assign acc_r     = (acc_q + AccW'(128)) >>> 8;
  assign bearing_o = zero_q ? '0 : acc_r[AngW-1:0];
  assign done_o    = done_q;

endmodule

>>> rtl/core/gcbv_div.sv
// Restoring divider, one quotient bit per cycle, for the beam index.
// Depends on gcbv_pkg.
module gcbv_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [gcbv_pkg::NumW-1:0]   dividend_i,
  input  logic [15:0]                 divisor_i,
  output logic                        done_o,
  output logic [gcbv_pkg::NumW-1:0]   quot_o
);
  import gcbv_pkg::*;

  logic [15:0]      rem_q, div_q;
  logic [NumW-1:0]  quo_q;
  logic [StepW-1:0] cnt_q;
  logic             busy_q, done_q, ge;
  logic [16:0]      trial, diff;

  assign trial = {rem_q, quo_q[NumW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == StepW'(NumW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      div_q <= (divisor_i == '0) ? 16'd1 : divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[15:0] : trial[15:0];
      quo_q <= {quo_q[NumW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> rtl/core/grid_cell_beam_visibility_top.sv
// Top level of the grid cell beam visibility block: sequencer, scan table,
// shared squaring multiplier. Depends on gcbv_pkg, gcbv_cordic, gcbv_div.
//
// Load beats are taken back to back while the sequencer is idle. A query
// holds the input from its beat to the next beat while it runs through its
// steps: start the CORDIC, its iterations and done, the angle, the serial
// beam-index divider (start plus one step for each quotient bit), the table
// read, 3 multiplies, the compare and back in idle. A stalled earlier result
// holds the compare step until the output register is free.
// The input is not ready while a query is in flight; a finished result waits
// in the output register and the next beat may be taken meanwhile.
// Reset (rst_ni, async, active low) clears control and the configuration
// registers (cell size 10, beam spacing 256, field of view 240). The scan table
// is not cleared; beams must be loaded before a query reads them.
module grid_cell_beam_visibility_top #(
  parameter int unsigned BEAMS        = gcbv_pkg::BeamsDef,
  parameter int unsigned CORDIC_STEPS = gcbv_pkg::CordicStepsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] beam, [23:8] range_value, [39:24] cell_index, [55:40] pose_x,
  // [71:56] pose_y, [89:72] pose_heading, [95:90] zero
  input  logic [95:0] s_axis_tdata,
  input  logic        s_axis_tuser,   // [0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [0] visible, [7:1] zero
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import gcbv_pkg::*;

  localparam int unsigned BeamW = $clog2(BEAMS);

  // sequencer codes
  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StPrep = 4'd1;
  localparam logic [3:0] StCord = 4'd2;
  localparam logic [3:0] StAng  = 4'd3;
  localparam logic [3:0] StDiv  = 4'd4;
  localparam logic [3:0] StRd   = 4'd5;
  localparam logic [3:0] StSqx  = 4'd6;
  localparam logic [3:0] StSqy  = 4'd7;
  localparam logic [3:0] StSqr  = 4'd8;
  localparam logic [3:0] StCmp  = 4'd9;

  logic [3:0] state_q, state_d;

  // config
  logic [7:0]  cell_size_q;
  logic [15:0] spacing_q;
  logic [8:0]  fov_q;

  // input fields
  logic [7:0]  in_beam;
  logic [15:0] in_range, in_cell;
  logic signed [15:0] in_px, in_py;
  logic signed [17:0] in_hd;
  logic in_acc;

  assign in_beam  = s_axis_tdata[7:0];
  assign in_range = s_axis_tdata[23:8];
  assign in_cell  = s_axis_tdata[39:24];
  assign in_px    = s_axis_tdata[55:40];
  assign in_py    = s_axis_tdata[71:56];
  assign in_hd    = s_axis_tdata[89:72];
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_size_q <= 8'd10;
      spacing_q   <= 16'd256;
      fov_q       <= 9'd240;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgCellSize:    cell_size_q <= cfg_data_i[7:0];
        CfgBeamSpacing: spacing_q   <= cfg_data_i;
        CfgFov:         fov_q       <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // scan table: written on load beats, read once per query
  logic [15:0] scan_mem [BEAMS];
  logic [15:0] range_q;
  logic [BeamW-1:0] beam_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && (s_axis_tuser == OpLoad) && (32'(in_beam) < 32'(BEAMS)))
      scan_mem[BeamW'(in_beam)] <= in_range;
    if (state_q == StRd)
      range_q <= scan_mem[beam_q];
  end

  // cell position relative to pose
  logic [15:0] colp, rowp;
  logic signed [PosW-1:0] dx_c, dy_c, dx_q, dy_q;
  logic signed [17:0] hd_q;

  assign colp = in_cell[GridWidthLog2-1:0] * cell_size_q;
  assign rowp = in_cell[15:GridWidthLog2] * cell_size_q;
  assign dx_c = $signed({2'b00, colp}) - PosW'(in_px);
  assign dy_c = $signed({2'b00, rowp}) - PosW'(in_py);

  // shared units
  logic cord_start, cord_done, div_start, div_done;
  logic signed [AngW-1:0] bearing, angle_q, num;
  logic [NumW-1:0] quot, dividend;

  gcbv_cordic #(.Steps(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni,
    .start_i  (cord_start),
    .dx_i     (dx_q),
    .dy_i     (dy_q),
    .done_o   (cord_done),
    .bearing_o(bearing)
  );

  assign num      = angle_q + Offset120;
  assign dividend = num[AngW-1] ? '0 : num[NumW-1:0];

  gcbv_div u_div (
    .clk_i, .rst_ni,
    .start_i   (div_start),
    .dividend_i(dividend),
    .divisor_i (spacing_q),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  assign cord_start = (state_q == StPrep);
  assign div_start  = (state_q == StAng);

  // angle check: truncated whole degrees, twice its magnitude against the FOV
  logic [AngW-1:0] ang_abs;
  logic [10:0]     twice_deg;
  logic            fov_ok_q;

  assign ang_abs   = angle_q[AngW-1] ? AngW'(-angle_q) : AngW'(angle_q);
  assign twice_deg = {ang_abs[17:8], 1'b0};

  // one multiplier shared by dx^2, dy^2 and range^2
  logic [16:0] mul_a, ax, ay;
  logic [33:0] prod;
  logic [34:0] d2_q;
  logic [33:0] p_q, rr_q;

  assign ax = dx_q[PosW-1] ? 17'(-dx_q) : 17'(dx_q);
  assign ay = dy_q[PosW-1] ? 17'(-dy_q) : 17'(dy_q);

  always_comb begin
    case (state_q)
      StSqx:   mul_a = ax;
      StSqy:   mul_a = ay;
      default: mul_a = {1'b0, range_q};
    endcase
  end
  assign prod = mul_a * mul_a;

  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_acc && (s_axis_tuser == OpQuery)) state_d = StPrep;
      StPrep: state_d = StCord;
      StCord: if (cord_done) state_d = StAng;
      StAng:  state_d = StDiv;
      StDiv:  if (div_done) state_d = StRd;
      StRd:   state_d = StSqx;
      StSqx:  state_d = StSqy;
      StSqy:  state_d = StSqr;
      StSqr:  state_d = StCmp;
      StCmp:  if (out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign s_axis_tready = (state_q == StIdle);

  logic vis_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StCmp && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready)           m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      dx_q <= dx_c;
      dy_q <= dy_c;
      hd_q <= in_hd;
    end
    if (cord_done)
      angle_q <= bearing - AngW'(hd_q);
    if (state_q == StAng)
      fov_ok_q <= !(twice_deg > {2'b00, fov_q});
    if (div_done)
      beam_q <= (quot > NumW'(BEAMS - 1)) ? BeamW'(BEAMS - 1) : quot[BeamW-1:0];
    if (state_q == StSqx) p_q  <= prod;
    if (state_q == StSqy) d2_q <= {1'b0, p_q} + {1'b0, prod};
    if (state_q == StSqr) rr_q <= prod;
    if (state_q == StCmp && out_free)
      vis_q <= fov_ok_q && !(d2_q > {1'b0, rr_q});
  end

  assign m_axis_tdata = {7'b0, vis_q};

endmodule

>>> rtl/core/gcbv_checker.sv
// Port-level checks for the beam visibility top level, bound to it below.
// Depends only on the top level's ports.
module gcbv_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);

  // a result held back stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a query occupies the block: no beat taken the next cycle
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
    else $error("beat taken during query");

  // a load never produces a result
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result after load");

  // padding bits stay clear
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
    else $error("result padding not zero");

endmodule

bind grid_cell_beam_visibility_top gcbv_checker u_gcbv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
